// ----- rtl/fsfp_pkg.sv -----
// Package for the format specification parser: payload types, state types, character codes.
package fsfp_pkg;

    // Characters recognised inside a conversion specification
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LOW_L = 8'h6C;
    localparam logic [7:0] CH_LOW_H = 8'h68;
    localparam logic [7:0] CH_LOW_J = 8'h6A;
    localparam logic [7:0] CH_BIG_L = 8'h4C;

    localparam int FLAG_W = 7;
    localparam int LEN_W  = 6;
    localparam int CNT_W  = 16;

    // Bit positions in format_flags
    localparam int FL_DASH  = 0;
    localparam int FL_ZERO  = 1;
    localparam int FL_PLUS  = 2;
    localparam int FL_HASH  = 3;
    localparam int FL_SPACE = 4;
    localparam int FL_APOS  = 5;
    localparam int FL_STAR  = 6;

    // Bit positions in length_flags
    localparam int LN_L     = 0;
    localparam int LN_LL    = 1;
    localparam int LN_H     = 2;
    localparam int LN_HH    = 3;
    localparam int LN_J     = 4;
    localparam int LN_BIG_L = 5;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_WIDTH_RUN = 3'd1,
        MODE_PEND_L    = 3'd2,
        MODE_PEND_H    = 3'd3,
        MODE_AFTER_DOT = 3'd4,
        MODE_PREC_RUN  = 3'd5
    } scan_mode_t;

    typedef struct packed {
        logic        [7:0]  character;
        logic signed [31:0] star_value;
    } fsfp_in_t;

    typedef struct packed {
        logic        [7:0]        specifier;
        logic signed [31:0]       field_width;
        logic signed [31:0]       field_precision;
        logic                     precision_given;
        logic        [FLAG_W-1:0] format_flags;
        logic        [LEN_W-1:0]  length_flags;
        logic        [CNT_W-1:0]  consumed;
    } fsfp_out_t;

    typedef struct packed {
        logic [31:0]       width_acc;
        logic [31:0]       precision_acc;
        logic [FLAG_W-1:0] flag_bits;
        logic [LEN_W-1:0]  length_bits;
        logic              dot_seen;
        scan_mode_t        scan_mode;
        logic [CNT_W-1:0]  char_count;
    } fsfp_state_t;

    localparam fsfp_state_t STATE_CLEAR = '{
        width_acc:     32'd0,
        precision_acc: 32'd0,
        flag_bits:     '0,
        length_bits:   '0,
        dot_seen:      1'b0,
        scan_mode:     MODE_IDLE,
        char_count:    '0
    };

    // acc * 10 + digit, as two shifts and adds, wrapping at 32 bits
    function automatic logic [31:0] mul10_add(input logic [31:0] acc, input logic [3:0] dig);
        return (acc << 3) + (acc << 1) + {28'd0, dig};
    endfunction

endpackage

// ----- rtl/fsfp_step.sv -----
// One parsing step: classify a character and work out the next state and any result.
module fsfp_step (
    input  fsfp_pkg::fsfp_state_t st,
    input  fsfp_pkg::fsfp_in_t    item,
    output fsfp_pkg::fsfp_state_t st_next,
    output logic                  emit,
    output fsfp_pkg::fsfp_out_t   result
);
    import fsfp_pkg::*;

    logic [7:0]  c;
    logic        is_dig;
    logic [3:0]  dig;
    logic        taken;
    fsfp_state_t ns;
    logic [31:0] neg_star;

    assign c        = item.character;
    assign is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);
    assign dig      = c[3:0];
    assign neg_star = 32'd0 - item.star_value;

    always_comb begin
        ns     = st;
        taken  = 1'b0;
        emit   = 1'b0;
        result = '0;

        // Finish or continue what the previous character left open
        unique case (st.scan_mode)
            MODE_PEND_L: begin
                ns.scan_mode = MODE_IDLE;
                if (c == CH_LOW_L) begin
                    ns.length_bits[LN_LL] = 1'b1;
                    taken = 1'b1;
                end else begin
                    ns.length_bits[LN_L] = 1'b1;
                end
            end
            MODE_PEND_H: begin
                ns.scan_mode = MODE_IDLE;
                if (c == CH_LOW_H) begin
                    ns.length_bits[LN_HH] = 1'b1;
                    taken = 1'b1;
                end else begin
                    ns.length_bits[LN_H] = 1'b1;
                end
            end
            MODE_WIDTH_RUN: begin
                if (is_dig) begin
                    ns.width_acc = mul10_add(st.width_acc, dig);
                    taken = 1'b1;
                end else begin
                    ns.scan_mode = MODE_IDLE;
                end
            end
            MODE_AFTER_DOT: begin
                ns.scan_mode = MODE_IDLE;
                if (c == CH_STAR) begin
                    ns.precision_acc = item.star_value;
                    if (item.star_value[31]) ns.dot_seen = 1'b0;
                    taken = 1'b1;
                end else if (is_dig) begin
                    ns.precision_acc = mul10_add(st.precision_acc, dig);
                    ns.scan_mode     = MODE_PREC_RUN;
                    taken = 1'b1;
                end else if (st.precision_acc[31]) begin
                    ns.dot_seen = 1'b0;
                end
            end
            MODE_PREC_RUN: begin
                if (is_dig) begin
                    ns.precision_acc = mul10_add(st.precision_acc, dig);
                    taken = 1'b1;
                end else begin
                    ns.scan_mode = MODE_IDLE;
                    if (st.precision_acc[31]) ns.dot_seen = 1'b0;
                end
            end
            default: begin
                ns.scan_mode = MODE_IDLE;
            end
        endcase

        // Idle classification
        if (!taken) begin
            priority if (c == CH_DASH) begin
                ns.flag_bits[FL_DASH] = 1'b1;
                ns.flag_bits[FL_ZERO] = 1'b0;
            end else if (c == CH_ZERO && !ns.flag_bits[FL_DASH]) begin
                ns.flag_bits[FL_ZERO] = 1'b1;
            end else if (c == CH_PLUS) begin
                ns.flag_bits[FL_PLUS] = 1'b1;
            end else if (c == CH_HASH) begin
                ns.flag_bits[FL_HASH] = 1'b1;
            end else if (c == CH_SPACE) begin
                ns.flag_bits[FL_SPACE] = 1'b1;
            end else if (c == CH_APOS) begin
                ns.flag_bits[FL_APOS] = 1'b1;
            end else if (c == CH_LOW_L) begin
                ns.scan_mode = MODE_PEND_L;
            end else if (c == CH_LOW_H) begin
                ns.scan_mode = MODE_PEND_H;
            end else if (c == CH_LOW_J) begin
                ns.length_bits[LN_J] = 1'b1;
            end else if (c == CH_BIG_L) begin
                ns.length_bits[LN_BIG_L] = 1'b1;
            end else if (is_dig) begin
                ns.width_acc = mul10_add(ns.width_acc, dig);
                ns.scan_mode = MODE_WIDTH_RUN;
            end else if (c == CH_STAR) begin
                if (item.star_value[31]) begin
                    ns.width_acc          = neg_star;
                    ns.flag_bits[FL_DASH] = 1'b1;
                    ns.flag_bits[FL_ZERO] = 1'b0;
                end else begin
                    ns.width_acc = item.star_value;
                end
                ns.flag_bits[FL_STAR] = 1'b1;
            end else if (c == CH_DOT) begin
                ns.dot_seen  = 1'b1;
                ns.scan_mode = MODE_AFTER_DOT;
            end else begin
                emit                   = 1'b1;
                result.specifier       = c;
                result.field_width     = ns.width_acc;
                result.field_precision = ns.precision_acc;
                result.precision_given = ns.dot_seen;
                result.format_flags    = ns.flag_bits;
                result.length_flags    = ns.length_bits;
                result.consumed        = ns.char_count;
            end
        end

        if (emit) begin
            st_next = STATE_CLEAR;
        end else begin
            st_next = ns;
            if (ns.char_count != CNT_MAX) st_next.char_count = ns.char_count + 1'b1;
        end
    end

endmodule

// ----- rtl/format_spec_flag_parser.sv -----
// Top level of the format specification parser: request registers, parse state, result register.
//
//  channel  dir  handshake          payload
//  s_       in   s_valid / s_ready  s_item  (character, star_value)
//  m_       out  m_valid / m_ready  m_item  (specifier ... consumed)
//
// One request per cycle sustained, except while a specifier waits on a stalled result.
// A request enters the input register, is parsed by one step of shift-add and compare logic,
// and its result (on the specifier only) lands in the result register that drives m_valid.
// Synchronous active-low reset clears the parse state and both valid flags.
// A stalled result holds the step only when the request in the input register would emit;
// requests that emit nothing keep flowing past a full result register.
module format_spec_flag_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fsfp_pkg::fsfp_in_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output fsfp_pkg::fsfp_out_t m_item
);
    import fsfp_pkg::*;

    logic        in_valid_reg, in_valid_next;
    fsfp_in_t    in_item_reg;
    fsfp_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    fsfp_out_t   out_item_reg;

    fsfp_state_t step_state;
    logic        step_emit;
    fsfp_out_t   step_result;
    logic        out_free;
    logic        advance;

    fsfp_step u_step (
        .st      (state_reg),
        .item    (in_item_reg),
        .st_next (step_state),
        .emit    (step_emit),
        .result  (step_result)
    );

    // Advance the held request unless it emits into a full, stalled result register
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!step_emit || out_free);
    assign s_ready  = !in_valid_reg || advance;

    assign in_valid_next  = s_ready ? s_valid : in_valid_reg;
    assign state_next     = advance ? step_state : state_reg;
    assign out_valid_next = (advance && step_emit) ? 1'b1 :
                            (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_CLEAR;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers: load on acceptance, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_item_reg <= s_item;
        if (advance && step_emit) out_item_reg <= step_result;
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // A step that emits always leaves a result waiting
    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && step_emit |=> out_valid_reg)
        else $error("emitted result not presented");

    // A specifier leaves the parse state cleared
    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && step_emit |=> state_reg == STATE_CLEAR)
        else $error("state not cleared after specifier");

    // Parse state moves only when a request is stepped
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("state changed without a step");

    // An empty input register always takes a request
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input register empty but not ready");

endmodule

// ----- tb/sv/fsfp_spec_checker.sv -----
// Scoreboard for the format specification parser: predicts each result and compares it.
`timescale 1ns / 100ps

module fsfp_spec_checker
    import fsfp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  fsfp_in_t  s_item,
    input  logic      m_valid,
    input  logic      m_ready,
    input  fsfp_out_t m_item,
    output int        mismatch_total,
    output int        specs_due
);

    // Shadow copy of the parse state
    logic [31:0]       width_acc;
    logic [31:0]       prec_acc;
    logic [FLAG_W-1:0] flag_bits;
    logic [LEN_W-1:0]  len_bits;
    logic              dot_seen;
    scan_mode_t        scan_mode;
    logic [CNT_W-1:0]  char_count;

    fsfp_out_t pending_specs[$];

    function automatic logic [31:0] tenfold_plus(input logic [31:0] acc, input logic [7:0] c);
        logic [7:0] digit;
        digit = c - CH_ZERO;
        return acc * 32'd10 + {24'd0, digit};
    endfunction

    task automatic clear_spec();
        width_acc  = '0;
        prec_acc   = '0;
        flag_bits  = '0;
        len_bits   = '0;
        dot_seen   = 1'b0;
        scan_mode  = MODE_IDLE;
        char_count = '0;
    endtask

    // Advance the shadow state by one character; emit is set on the specifier.
    task automatic parse_spec_char(input fsfp_in_t req, output bit emit, output fsfp_out_t res);
        logic [7:0]  c;
        logic [31:0] sv;
        bit          taken;
        bit          is_digit;
        c        = req.character;
        sv       = req.star_value;
        taken    = 1'b0;
        emit     = 1'b0;
        res      = '0;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

        case (scan_mode)
            MODE_PEND_L: begin
                scan_mode = MODE_IDLE;
                if (c == CH_LOW_L) begin
                    len_bits[LN_LL] = 1'b1;
                    taken = 1'b1;
                end else begin
                    len_bits[LN_L] = 1'b1;
                end
            end
            MODE_PEND_H: begin
                scan_mode = MODE_IDLE;
                if (c == CH_LOW_H) begin
                    len_bits[LN_HH] = 1'b1;
                    taken = 1'b1;
                end else begin
                    len_bits[LN_H] = 1'b1;
                end
            end
            MODE_WIDTH_RUN: begin
                if (is_digit) begin
                    width_acc = tenfold_plus(width_acc, c);
                    taken = 1'b1;
                end else begin
                    scan_mode = MODE_IDLE;
                end
            end
            MODE_AFTER_DOT: begin
                if (c == CH_STAR) begin
                    prec_acc = sv;
                    if (prec_acc[31]) dot_seen = 1'b0;
                    scan_mode = MODE_IDLE;
                    taken = 1'b1;
                end else if (is_digit) begin
                    prec_acc  = tenfold_plus(prec_acc, c);
                    scan_mode = MODE_PREC_RUN;
                    taken = 1'b1;
                end else begin
                    if (prec_acc[31]) dot_seen = 1'b0;
                    scan_mode = MODE_IDLE;
                end
            end
            MODE_PREC_RUN: begin
                if (is_digit) begin
                    prec_acc = tenfold_plus(prec_acc, c);
                    taken = 1'b1;
                end else begin
                    if (prec_acc[31]) dot_seen = 1'b0;
                    scan_mode = MODE_IDLE;
                end
            end
            default: begin
                scan_mode = MODE_IDLE;
            end
        endcase

        if (!taken) begin
            if (c == CH_DASH) begin
                flag_bits[FL_DASH] = 1'b1;
                flag_bits[FL_ZERO] = 1'b0;
            end else if (c == CH_ZERO && !flag_bits[FL_DASH]) begin
                flag_bits[FL_ZERO] = 1'b1;
            end else if (c == CH_PLUS) begin
                flag_bits[FL_PLUS] = 1'b1;
            end else if (c == CH_HASH) begin
                flag_bits[FL_HASH] = 1'b1;
            end else if (c == CH_SPACE) begin
                flag_bits[FL_SPACE] = 1'b1;
            end else if (c == CH_APOS) begin
                flag_bits[FL_APOS] = 1'b1;
            end else if (c == CH_LOW_L) begin
                scan_mode = MODE_PEND_L;
            end else if (c == CH_LOW_H) begin
                scan_mode = MODE_PEND_H;
            end else if (c == CH_LOW_J) begin
                len_bits[LN_J] = 1'b1;
            end else if (c == CH_BIG_L) begin
                len_bits[LN_BIG_L] = 1'b1;
            end else if (is_digit) begin
                width_acc = tenfold_plus(width_acc, c);
                scan_mode = MODE_WIDTH_RUN;
            end else if (c == CH_STAR) begin
                width_acc = sv;
                // negative star width turns into left alignment
                if (width_acc[31]) begin
                    flag_bits[FL_DASH] = 1'b1;
                    flag_bits[FL_ZERO] = 1'b0;
                    width_acc = 32'd0 - width_acc;
                end
                flag_bits[FL_STAR] = 1'b1;
            end else if (c == CH_DOT) begin
                dot_seen  = 1'b1;
                scan_mode = MODE_AFTER_DOT;
            end else begin
                emit                = 1'b1;
                res.specifier       = c;
                res.field_width     = width_acc;
                res.field_precision = prec_acc;
                res.precision_given = dot_seen;
                res.format_flags    = flag_bits;
                res.length_flags    = len_bits;
                res.consumed        = char_count;
                clear_spec();
            end
        end

        if (!emit && char_count != CNT_MAX) char_count = char_count + 1'b1;
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge aclk) begin : watch
        fsfp_out_t want;
        fsfp_out_t predicted;
        bit        emit;
        if (!aresetn) begin
            clear_spec();
            pending_specs.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_specs.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, m_item);
                    mismatch_total++;
                end else begin
                    want = pending_specs.pop_front();
                    check_field("specifier", want.specifier, m_item.specifier);
                    check_field("field_width", want.field_width, m_item.field_width);
                    check_field("field_precision", want.field_precision,
                                m_item.field_precision);
                    check_field("precision_given", want.precision_given,
                                m_item.precision_given);
                    check_field("format_flags", want.format_flags, m_item.format_flags);
                    check_field("length_flags", want.length_flags, m_item.length_flags);
                    check_field("consumed", want.consumed, m_item.consumed);
                end
            end
            if (s_valid && s_ready) begin
                parse_spec_char(s_item, emit, predicted);
                if (emit) pending_specs.push_back(predicted);
            end
        end
        specs_due <= pending_specs.size();
    end

endmodule

// ----- tb/sv/tb_format_spec_flag_parser.sv -----
// Testbench top for the format specification parser: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_format_spec_flag_parser;
    import fsfp_pkg::*;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    fsfp_in_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    fsfp_out_t m_item;

    int   fail_count;
    int   specs_due;
    int   tx_idle = 0;       // percentage of cycles the sender holds back
    int   rx_idle = 0;       // percentage of cycles the receiver holds back
    logic rx_hold = 1'b0;    // long receiver hold-off, set by hold_results
    int   accepted_count = 0;

    format_spec_flag_parser u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    fsfp_spec_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item         (s_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item         (m_item),
        .mismatch_total (fail_count),
        .specs_due      (specs_due)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: drop ready at random, and hold it low throughout a hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !rx_hold && ($urandom_range(99) >= rx_idle);
        end
    end

    // Watchdog: stop a hung run long after the slowest correct one would finish
    initial begin
        #5_000_000;
        $display("tb_format_spec_flag_parser NOT OK");
        $finish;
    end

    // Offer one request, after a random number of idle cycles, and hold it until taken.
    // Call right after a rising edge.
    task automatic send_char(input logic [7:0] c, input logic [31:0] sv);
        while ($urandom_range(99) < tx_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= '{character: c, star_value: sv};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        accepted_count++;
    endtask

    // Hold the receiver off for a fixed number of cycles
    task automatic hold_results(input int cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge aclk);
        rx_hold <= 1'b0;
    endtask

    // Star values: mostly the interesting corners, the rest anything at all
    function automatic logic [31:0] pick_star();
        case ($urandom_range(5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return $urandom_range(40);
            4:       return 32'd0 - $urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    // True for a byte that no rule of the parser takes, so it ends the specification
    function automatic bit ends_spec(input logic [7:0] c);
        return !((c >= CH_ZERO && c <= CH_NINE) || c == CH_DASH || c == CH_PLUS ||
                 c == CH_HASH || c == CH_SPACE || c == CH_APOS || c == CH_STAR ||
                 c == CH_DOT || c == CH_LOW_L || c == CH_LOW_H || c == CH_LOW_J ||
                 c == CH_BIG_L);
    endfunction

    task automatic send_digits(input int count);
        repeat (count) send_char(CH_ZERO + 8'($urandom_range(9)), $urandom);
    endtask

    // One well-formed specification: up to six pieces of flags, widths, precisions and length
    // marks in any order, then a specifier
    task automatic send_random_spec();
        string      conv;
        int         pieces;
        logic [7:0] term;
        conv   = "diouxXeEfFgGaAcspn%";
        pieces = $urandom_range(6);
        repeat (pieces) begin
            case ($urandom_range(4))
                0: begin
                    case ($urandom_range(5))
                        0:       send_char(CH_DASH, $urandom);
                        1:       send_char(CH_ZERO, $urandom);
                        2:       send_char(CH_PLUS, $urandom);
                        3:       send_char(CH_HASH, $urandom);
                        4:       send_char(CH_SPACE, $urandom);
                        default: send_char(CH_APOS, $urandom);
                    endcase
                end
                1: send_digits($urandom_range(1, 12));
                2: send_char(CH_STAR, pick_star());
                3: begin
                    send_char(CH_DOT, $urandom);
                    case ($urandom_range(2))
                        0:       ;
                        1:       send_digits($urandom_range(1, 12));
                        default: send_char(CH_STAR, pick_star());
                    endcase
                end
                default: begin
                    case ($urandom_range(5))
                        0: send_char(CH_LOW_L, $urandom);
                        1: begin
                            send_char(CH_LOW_L, $urandom);
                            send_char(CH_LOW_L, $urandom);
                        end
                        2: send_char(CH_LOW_H, $urandom);
                        3: begin
                            send_char(CH_LOW_H, $urandom);
                            send_char(CH_LOW_H, $urandom);
                        end
                        4:       send_char(CH_LOW_J, $urandom);
                        default: send_char(CH_BIG_L, $urandom);
                    endcase
                end
            endcase
        end
        if ($urandom_range(3) == 0) begin
            do term = 8'($urandom_range(255)); while (!ends_spec(term));
        end else begin
            term = conv[$urandom_range(conv.len() - 1)];
        end
        send_char(term, $urandom);
    endtask

    // Mostly well-formed specifications, the rest single random bytes
    task automatic send_random_mix(input int count);
        int target;
        target = accepted_count + count;
        while (accepted_count < target) begin
            if ($urandom_range(99) < 85) send_random_spec();
            else send_char(8'($urandom_range(255)), $urandom);
        end
    endtask

    initial begin
        tx_idle <= 24;
        rx_idle <= 56;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Bare specifier
        send_char("d", 32'd0);
        // Every flag, the most negative star width, a negative star precision, ll
        send_char(CH_DASH, 32'd0);
        send_char(CH_ZERO, 32'd0);
        send_char(CH_PLUS, 32'd0);
        send_char(CH_HASH, 32'd0);
        send_char(CH_SPACE, 32'd0);
        send_char(CH_APOS, 32'd0);
        send_char(CH_STAR, 32'h8000_0000);
        send_char(CH_DOT, 32'd0);
        send_char(CH_STAR, 32'hFFFF_FFFF);
        send_char(CH_LOW_L, 32'd0);
        send_char(CH_LOW_L, 32'd0);
        send_char("x", 32'd0);
        // Dash clears zero, then a zero after dash starts the width; hh
        send_char(CH_ZERO, 32'd0);
        send_char(CH_DASH, 32'd0);
        send_char(CH_ZERO, 32'd0);
        send_char("7", 32'd0);
        send_char(CH_LOW_H, 32'd0);
        send_char(CH_LOW_H, 32'd0);
        send_char("u", 32'd0);
        // Dot with nothing after it
        send_char(CH_DOT, 32'hFFFF_FFFF);
        send_char("f", 32'd0);
        // Largest star width, j, L, and a single h cut short by the specifier
        send_char(CH_STAR, 32'h7FFF_FFFF);
        send_char(CH_LOW_J, 32'd0);
        send_char(CH_BIG_L, 32'd0);
        send_char(CH_LOW_H, 32'd0);
        send_char("g", 32'd0);
        // NUL and the top byte as specifiers
        send_char(8'h00, 32'hFFFF_FFFF);
        send_char(8'hFF, 32'h8000_0000);

        send_random_mix(340);

        tx_idle <= 56;
        rx_idle <= 24;
        send_random_mix(340);

        tx_idle <= 0;
        rx_idle <= 0;
        // Hold results back while requests keep coming, so the block backs up
        fork
            hold_results(300);
            repeat (30) begin
                send_char("5", $urandom);
                send_char("d", $urandom);
            end
        join
        send_random_mix(340);

        s_valid <= 1'b0;

        // Drain: let the last request through the pipeline, then wait for every result
        repeat (4) @(posedge aclk);
        while (specs_due != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (fail_count == 0 && specs_due == 0) begin
            $display("tb_format_spec_flag_parser OK");
        end else begin
            $display("tb_format_spec_flag_parser NOT OK");
        end
        $finish;
    end

endmodule
